/* rtl/cpf_pkg.sv */
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants for the contiguous packet FIFO.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int BUFFER_LIMIT = 512;
  localparam int MAX_PACKET   = 70;
  localparam int STORE_DEPTH  = BUFFER_LIMIT + MAX_PACKET + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int PTR_W        = $clog2(BUFFER_LIMIT);
  localparam int SUM_W        = ADDR_W + 1;
  localparam int LEN_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int DROP_END     = 127;

  typedef enum logic {
    KIND_APPEND = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_READ    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WR_DATA,
    ST_RD_LEN,
    ST_RD_DATA
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   packet_len;
  } cpf_in_t;

  typedef struct packed {
    status_e            status;
    logic [BYTE_W-1:0]  read_byte;
    logic               last_of_packet;
    logic [LEN_W-1:0]   head_length;
  } cpf_out_t;

  typedef struct packed {
    logic item_load;
    logic len_write;
    logic append_finish;
    logic head_read;
    logic byte_read;
    logic read_finish;
    logic empty_finish;
  } cpf_cmd_t;

  typedef struct packed {
    logic is_read;
    logic first;
    logic admit;
    logic empty;
    logic out_busy;
  } cpf_stat_t;

endpackage

/* rtl/cpf_ctrl.sv */
// ----------------------------------------------------------------------------
// cpf_ctrl
// Sequencer: accepts one item, steps the datapath through its memory
// accesses and hands the result to the output register.
// ----------------------------------------------------------------------------
module cpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpf_pkg::cpf_stat_t stat_i,
  output cpf_pkg::cpf_cmd_t  cmd_o
);
  import cpf_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE) || stat_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.is_read) begin
          state_d = stat_i.empty ? ST_IDLE : ST_RD_LEN;
        end else begin
          state_d = (stat_i.first && stat_i.admit) ? ST_WR_DATA : ST_IDLE;
        end
      end
      ST_WR_DATA: state_d = ST_IDLE;
      ST_RD_LEN:  state_d = ST_RD_DATA;
      ST_RD_DATA: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.item_load = accept;
      ST_DECIDE: begin
        if (stat_i.is_read) begin
          if (stat_i.empty) cmd_o.empty_finish = 1'b1;
          else              cmd_o.head_read    = 1'b1;
        end else begin
          if (stat_i.first && stat_i.admit) cmd_o.len_write     = 1'b1;
          else                              cmd_o.append_finish = 1'b1;
        end
      end
      ST_WR_DATA: cmd_o.append_finish = 1'b1;
      ST_RD_LEN:  cmd_o.byte_read     = 1'b1;
      ST_RD_DATA: cmd_o.read_finish   = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

endmodule

/* rtl/cpf_dpath.sv */
// ----------------------------------------------------------------------------
// cpf_dpath
// Byte store, read/write pointers, append and read progress, admission
// check and the output register.
// ----------------------------------------------------------------------------
module cpf_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpf_pkg::cpf_in_t   in_item_i,
  input  cpf_pkg::cpf_cmd_t  cmd_i,
  output cpf_pkg::cpf_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cpf_pkg::cpf_out_t  out_item_o
);
  import cpf_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  cpf_in_t           item_q;
  logic [PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d, off_q, off_d, alen_q;
  logic              drop_q, drop_d;
  logic [BYTE_W-1:0] hlen_q;
  cpf_out_t          out_q, out_d;
  logic              out_valid_q;

  logic [SUM_W-1:0]  pkt_end, wp_sum, rp_sum;
  logic              admit, first, drop_now, app_last, rd_last;
  logic [LEN_W-1:0]  app_len;
  logic [LEN_W:0]    cnt_inc, off_inc;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [BYTE_W-1:0] wdata;

  assign pkt_end = SUM_W'(wp_q) + SUM_W'(item_q.packet_len) + SUM_W'(1);
  assign admit   = (item_q.packet_len != '0)
                && (item_q.packet_len <= LEN_W'(MAX_PACKET))
                && !((rp_q == '0) && (pkt_end >= SUM_W'(BUFFER_LIMIT)))
                && ((pkt_end < SUM_W'(rp_q)) || (wp_q >= rp_q));
  assign first    = (cnt_q == '0);
  assign drop_now = first ? !admit : drop_q;
  assign app_len  = first ? item_q.packet_len : alen_q;
  assign cnt_inc  = (LEN_W+1)'(cnt_q) + (LEN_W+1)'(1);
  assign off_inc  = (LEN_W+1)'(off_q) + (LEN_W+1)'(1);

  assign app_last = drop_now
                  ? ((cnt_inc >= (LEN_W+1)'(item_q.packet_len))
                     || (cnt_inc >= (LEN_W+1)'(DROP_END)))
                  : (cnt_inc >= (LEN_W+1)'(app_len));
  assign rd_last  = ((BYTE_W+1)'(off_inc) >= (BYTE_W+1)'(hlen_q));
  assign wp_sum   = SUM_W'(wp_q) + SUM_W'(app_len) + SUM_W'(1);
  assign rp_sum   = SUM_W'(rp_q) + SUM_W'(hlen_q) + SUM_W'(1);

  assign stat_o.is_read  = (item_q.kind == KIND_READ);
  assign stat_o.first    = first;
  assign stat_o.admit    = admit;
  assign stat_o.empty    = (rp_q == wp_q);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(wp_q);
    wdata = item_q.data_byte;
    if (cmd_i.len_write) begin
      we    = 1'b1;
      wdata = BYTE_W'(item_q.packet_len);
    end else if (cmd_i.append_finish && !drop_now) begin
      we    = 1'b1;
      waddr = ADDR_W'(wp_q) + ADDR_W'(cnt_q) + ADDR_W'(1);
    end
    re    = cmd_i.head_read || cmd_i.byte_read;
    raddr = cmd_i.byte_read ? (ADDR_W'(rp_q) + ADDR_W'(off_q) + ADDR_W'(1))
                            : ADDR_W'(rp_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    cnt_d  = cnt_q;
    off_d  = off_q;
    drop_d = drop_q;
    out_d  = out_q;
    if (cmd_i.append_finish) begin
      out_d.status         = drop_now ? STAT_DROPPED : STAT_STORED;
      out_d.read_byte      = '0;
      out_d.last_of_packet = app_last;
      out_d.head_length    = '0;
      if (app_last) begin
        cnt_d  = '0;
        drop_d = 1'b0;
        if (!drop_now) begin
          wp_d = (wp_sum >= SUM_W'(BUFFER_LIMIT)) ? '0 : PTR_W'(wp_sum);
        end
      end else begin
        cnt_d  = cnt_inc[LEN_W-1:0];
        drop_d = drop_now;
      end
    end
    if (cmd_i.read_finish) begin
      out_d.status         = STAT_READ;
      out_d.read_byte      = rdata_q;
      out_d.last_of_packet = rd_last;
      out_d.head_length    = hlen_q[LEN_W-1:0];
      if (rd_last) begin
        rp_d  = (rp_sum >= SUM_W'(BUFFER_LIMIT)) ? '0 : PTR_W'(rp_sum);
        off_d = '0;
      end else begin
        off_d = off_inc[LEN_W-1:0];
      end
    end
    if (cmd_i.empty_finish) begin
      out_d = '{status: STAT_EMPTY, read_byte: '0, last_of_packet: 1'b0,
                head_length: '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      off_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      cnt_q  <= cnt_d;
      off_q  <= off_d;
      drop_q <= drop_d;
      if (cmd_i.append_finish || cmd_i.read_finish || cmd_i.empty_finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) item_q <= in_item_i;
    if (cmd_i.len_write) alen_q <= item_q.packet_len;
    if (cmd_i.byte_read) hlen_q <= rdata_q;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/contiguous_packet_fifo_core.sv */
// ----------------------------------------------------------------------------
// contiguous_packet_fifo_core
// Packet FIFO that keeps every packet contiguous in one byte store.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): one item is either an
// appended packet byte carrying the packet length, or a request to read one
// byte of the head packet. Output channel (out_valid_o / out_stall_i /
// out_item_o): exactly one result item per input item, in order.
// Each item goes through a small sequencer around a single-port byte store
// with a registered read: an item is taken in IDLE and its result is loaded
// into the output register from DECIDE, WR_DATA or RD_DATA. Appends finish
// in DECIDE, or write the length byte in DECIDE and the data byte in WR_DATA
// for the first byte of an admitted packet (length byte plus data byte).
// Reads look up the length in DECIDE and the data in RD_LEN, and finish in
// RD_DATA; on an empty store they finish in DECIDE. A new item is taken once the sequencer is idle.
// Reset clears the pointers and the append/read progress; the store holds
// no valid data until written and needs no clearing pass.
// While the receiver stalls, the result stays in the output register and
// in_stall_o stays high until that result is taken.
// ----------------------------------------------------------------------------
module contiguous_packet_fifo_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpf_pkg::cpf_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpf_pkg::cpf_out_t out_item_o
);
  import cpf_pkg::*;

  cpf_cmd_t  cmd;
  cpf_stat_t stat;

  cpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cpf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/packet_fifo_checker.sv */
// ----------------------------------------------------------------------------
// packet_fifo_checker
// Watches both channels of the contiguous packet FIFO. Every accepted item
// is run through a cycle-free model of the byte store and its pointers, and
// the expected result is queued. Every accepted result is compared field by
// field with the oldest queued one. Counts and a few state hints go back to
// the testbench top.
// ----------------------------------------------------------------------------
module packet_fifo_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  cpf_pkg::cpf_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  cpf_pkg::cpf_out_t out_item_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       dropped_o,
  output int unsigned       wraps_o,
  output int unsigned       empty_reads_o,
  output logic              head_at_base_o,
  output logic              store_empty_o
);
  import cpf_pkg::*;

  logic [BYTE_W-1:0] byte_mem [STORE_DEPTH];
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] wr_ptr;
  logic [LEN_W-1:0]  fill_cnt;
  logic              fill_drop;
  logic [LEN_W-1:0]  rd_off;
  int unsigned       wrap_tally;
  int unsigned       mismatch_tally;
  int unsigned       checked_tally;
  int unsigned       drop_tally;
  int unsigned       empty_tally;
  cpf_out_t          awaited_results[$];

  function automatic cpf_out_t fifo_answer(cpf_in_t it);
    cpf_out_t         r;
    logic [10:0]      span_end;
    logic [LEN_W-1:0] len;
    logic             fin;
    r = '0;
    r.status = STAT_STORED;
    fin = 1'b0;
    if (it.kind == KIND_APPEND) begin
      if (fill_cnt == 0) begin
        span_end = 11'(wr_ptr) + 11'(it.packet_len) + 11'd1;
        fill_drop = !(it.packet_len != 0 && it.packet_len <= MAX_PACKET &&
                      !(rd_ptr == 0 && span_end >= BUFFER_LIMIT) &&
                      (span_end < 11'(rd_ptr) || wr_ptr >= rd_ptr));
        if (!fill_drop) byte_mem[wr_ptr] = BYTE_W'(it.packet_len);
      end
      if (fill_drop) begin
        r.status = STAT_DROPPED;
        fin = (fill_cnt + 1 >= it.packet_len) || (fill_cnt + 1 >= DROP_END);
      end else begin
        // admitted packet: the length stored with its first byte decides the end
        len = byte_mem[wr_ptr][LEN_W-1:0];
        byte_mem[wr_ptr + ADDR_W'(fill_cnt) + ADDR_W'(1)] = it.data_byte;
        fin = (fill_cnt + 1 >= len);
        if (fin) begin
          wr_ptr = wr_ptr + ADDR_W'(len) + ADDR_W'(1);
          if (wr_ptr >= BUFFER_LIMIT) begin
            wr_ptr = '0;
            wrap_tally++;
          end
        end
      end
      r.last_of_packet = fin;
      if (fin) begin
        fill_cnt = '0;
        fill_drop = 1'b0;
      end else begin
        fill_cnt = fill_cnt + LEN_W'(1);
      end
    end else if (rd_ptr == wr_ptr) begin
      r.status = STAT_EMPTY;
    end else begin
      len = byte_mem[rd_ptr][LEN_W-1:0];
      r.status = STAT_READ;
      r.head_length = len;
      r.read_byte = byte_mem[rd_ptr + ADDR_W'(rd_off) + ADDR_W'(1)];
      fin = (rd_off + 1 >= len);
      r.last_of_packet = fin;
      if (fin) begin
        rd_ptr = rd_ptr + ADDR_W'(len) + ADDR_W'(1);
        if (rd_ptr >= BUFFER_LIMIT) begin
          rd_ptr = '0;
          wrap_tally++;
        end
        rd_off = '0;
      end else begin
        rd_off = rd_off + LEN_W'(1);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cpf_out_t want;
    logic     bad;
    if (!rst_ni) begin
      rd_ptr = '0;
      wr_ptr = '0;
      fill_cnt = '0;
      fill_drop = 1'b0;
      rd_off = '0;
      wrap_tally = 0;
      mismatch_tally = 0;
      checked_tally = 0;
      drop_tally = 0;
      empty_tally = 0;
      awaited_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) awaited_results.push_back(fifo_answer(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        checked_tally++;
        if (awaited_results.size() == 0) begin
          mismatch_tally++;
          if (mismatch_tally <= 10)
            $display("unexpected result: status=%0d byte=%02h last=%0d len=%0d",
                     out_item_i.status, out_item_i.read_byte,
                     out_item_i.last_of_packet, out_item_i.head_length);
        end else begin
          want = awaited_results.pop_front();
          if (want.status == STAT_DROPPED) drop_tally++;
          if (want.status == STAT_EMPTY) empty_tally++;
          bad = (want.status != out_item_i.status) ||
                (want.read_byte != out_item_i.read_byte) ||
                (want.last_of_packet != out_item_i.last_of_packet) ||
                (want.head_length != out_item_i.head_length);
          if (bad) begin
            mismatch_tally++;
            if (mismatch_tally <= 10)
              $display({"mismatch on result %0d: expected status=%0d byte=%02h",
                        " last=%0d len=%0d, got status=%0d byte=%02h last=%0d len=%0d"},
                       checked_tally, want.status, want.read_byte,
                       want.last_of_packet, want.head_length,
                       out_item_i.status, out_item_i.read_byte,
                       out_item_i.last_of_packet, out_item_i.head_length);
          end
        end
      end
    end
    mismatches_o   <= mismatch_tally;
    pending_o      <= awaited_results.size();
    checked_o      <= checked_tally;
    dropped_o      <= drop_tally;
    wraps_o        <= wrap_tally;
    empty_reads_o  <= empty_tally;
    head_at_base_o <= (rd_ptr == 0);
    store_empty_o  <= (rd_ptr == wr_ptr);
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for contiguous_packet_fifo_core. A short directed run
// covers empty reads, bad lengths and length changes inside packets; the
// random run then cycles through fill, drain, refill and mixed phases so that
// the store fills up, both pointers wrap and the reader-at-base drop occurs.
// Both sides idle at random and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;
  import cpf_pkg::*;

  localparam int ITEM_GOAL   = 1670;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {PH_FILL, PH_DRAIN, PH_REFILL, PH_MIXED} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  cpf_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  cpf_out_t    out_item_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned dropped;
  int unsigned wraps;
  int unsigned empty_reads;
  logic        head_at_base;
  logic        store_empty;

  int          send_max = 8;
  int          recv_max = 8;
  int          read_pct = 0;
  int          items_sent = 0;
  int          cycles = 0;
  bit          hold_pending = 1'b0;

  contiguous_packet_fifo_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  packet_fifo_checker fifo_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_i     (out_item_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .dropped_o      (dropped),
    .wraps_o        (wraps),
    .empty_reads_o  (empty_reads),
    .head_at_base_o (head_at_base),
    .store_empty_o  (store_empty)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic offer(cpf_in_t it);
    int gap;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic offer_append(logic [LEN_W-1:0] plen, logic [BYTE_W-1:0] data);
    cpf_in_t it;
    it.kind = KIND_APPEND;
    it.data_byte = data;
    it.packet_len = plen;
    offer(it);
  endtask

  task automatic offer_read();
    cpf_in_t it;
    it.kind = KIND_READ;
    it.data_byte = BYTE_W'($urandom_range(0, 255));
    it.packet_len = LEN_W'($urandom_range(0, 127));
    offer(it);
  endtask

  task automatic maybe_reads();
    while ($urandom_range(0, 99) < read_pct) offer_read();
  endtask

  task automatic random_packet();
    int               pick;
    int               sz;
    int               k;
    logic [LEN_W-1:0] bad_len;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // illegal length; sometimes cut short by a smaller length on byte two
      bad_len = ($urandom_range(0, 3) == 0) ? '0 :
                LEN_W'($urandom_range(MAX_PACKET + 1, DROP_END));
      maybe_reads();
      offer_append(bad_len, BYTE_W'($urandom_range(0, 255)));
      if (bad_len != 0) begin
        if ($urandom_range(0, 1) == 1) begin
          maybe_reads();
          offer_append(LEN_W'($urandom_range(0, 2)), BYTE_W'($urandom_range(0, 255)));
        end else begin
          for (k = 1; k < bad_len; k++) begin
            maybe_reads();
            offer_append(bad_len, BYTE_W'($urandom_range(0, 255)));
          end
        end
      end
    end else begin
      case ($urandom_range(0, 6))
        0:       sz = $urandom_range(1, 4);
        1:       sz = $urandom_range(64, MAX_PACKET);
        default: sz = $urandom_range(1, MAX_PACKET);
      endcase
      for (k = 0; k < sz; k++) begin
        maybe_reads();
        if (k > 0 && pick < 12)
          offer_append(LEN_W'($urandom_range(0, DROP_END)), BYTE_W'($urandom_range(0, 255)));
        else
          offer_append(LEN_W'(sz), BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver: random stall before each result, one long hold on request
  initial begin
    int stall_for;
    wait (rst_ni);
    forever begin
      if (hold_pending) begin
        stall_for = HOLD_CYCLES;
        hold_pending = 1'b0;
      end else begin
        stall_for = $urandom_range(0, recv_max);
      end
      if (stall_for > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_for) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    phase_e phase;
    int     phase_end;
    int     guard;
    bit     left_base;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    offer_read();
    offer_append(7'd1, 8'h00);
    offer_append(7'd0, 8'hFF);
    offer_append(7'd127, 8'h55);
    offer_append(7'd1, 8'hAA);
    offer_append(7'd71, 8'h12);
    offer_append(7'd2, 8'h34);
    offer_append(7'd3, 8'hFF);
    offer_read();
    offer_append(7'd1, 8'h80);
    offer_read();
    offer_append(7'd70, 8'h01);
    repeat (3) offer_read();
    offer_read();
    offer_append(7'd70, 8'hC3);
    offer_append(7'd70, 8'h3C);
    repeat (10) offer_read();
    offer_append(7'd2, 8'hAA);
    offer_append(7'd2, 8'h55);
    repeat (3) offer_read();

    // random phases
    phase = PH_FILL;
    while (items_sent < ITEM_GOAL) begin
      if (phase == PH_DRAIN) begin
        send_max = 0;
        recv_max = 8;
        guard = 0;
        left_base = !head_at_base;
        forever begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          if (store_empty || (head_at_base && left_base) || guard == 700) break;
          if (!head_at_base) left_base = 1'b1;
          offer_read();
          guard++;
        end
        phase = PH_REFILL;
      end else begin
        case (phase)
          PH_FILL: begin
            send_max = 0;
            recv_max = 0;
            read_pct = 4;
            phase_end = items_sent + 550;
          end
          PH_REFILL: begin
            send_max = 8;
            recv_max = 0;
            read_pct = 15;
            phase_end = items_sent + 400;
            hold_pending = 1'b1;
          end
          default: begin
            send_max = 8;
            recv_max = 8;
            read_pct = 50;
            phase_end = items_sent + 300;
          end
        endcase
        while (items_sent < phase_end && items_sent < ITEM_GOAL) random_packet();
        case (phase)
          PH_FILL:   phase = PH_DRAIN;
          PH_REFILL: phase = PH_MIXED;
          default:   phase = PH_FILL;
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d items offered, %0d results checked, %0d of them dropped appends",
             items_sent, checked, dropped);
    $display("%0d pointer wraps, %0d reads of an empty store", wraps, empty_reads);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
